// File: sv/srd_pkg.sv
package srd_pkg;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SOCKET,
		PH_LENGTH,
		PH_LINEFEEDS,
		PH_PAYLOAD
	} phase_t;

	// "+SKTRPT" as the seven bytes before the final '='
	localparam logic [55:0] HEADER_WORD = 56'h2B_53_4B_54_52_50_54;
	localparam logic [7:0]  HEADER_LAST = 8'h3D;
	localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
	localparam logic [7:0]  CHAR_LF     = 8'h0A;
	localparam logic [7:0]  CHAR_ZERO   = 8'h30;
	localparam logic [7:0]  CHAR_NINE   = 8'h39;
	localparam logic [15:0] ACC_MAX     = 16'hFFFF;

endpackage

// File: sv/socket_report_deframer.sv
// Socket report deframer. Takes one received byte per cycle on the rx channel, hunts for
// "+SKTRPT=", parses "<socket>,<length>," in decimal (non-digits ignored, values saturate
// at 65535, a field longer than MAX_FIELD_CHARS characters drops back to the hunt), waits
// for LINEFEEDS_BEFORE_DATA line feeds, then forwards exactly <length> bytes tagged with the
// socket number, frame_last on the final one. A zero-length frame forwards nothing. Each byte
// is registered, parsed combinationally and its payload word registered at the output. One
// byte is accepted every cycle, and in_ready drops only while a payload byte waits behind a
// result word not yet taken.
module socket_report_deframer
	import srd_pkg::*;
#(
	parameter int MAX_FIELD_CHARS       = 9,
	parameter int LINEFEEDS_BEFORE_DATA = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic [15:0] socket_id,
	output logic        frame_last
);

	localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);
	localparam int LF_W  = $clog2(LINEFEEDS_BEFORE_DATA + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELD_CHARS);
	localparam logic [LF_W-1:0]  LF_MAX  = LF_W'(LINEFEEDS_BEFORE_DATA);

	logic             valid_s1;
	logic [7:0]       byte_s1;

	phase_t           phase_q, phase_d;
	logic [55:0]      hist_q, hist_d;
	logic [CNT_W-1:0] fcnt_q, fcnt_d;
	logic [15:0]      sock_q, sock_d;
	logic [15:0]      len_q, len_d;
	logic [LF_W-1:0]  lfcnt_q, lfcnt_d;
	logic [15:0]      remain_q, remain_d;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [15:0]      out_sock_q;
	logic             out_last_q;

	logic             produce;
	logic             out_free;
	logic             advance;
	logic             is_last;
	logic [15:0]      field_acc;
	logic [15:0]      acc_next;
	logic [19:0]      acc_ext;
	logic             is_digit;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!produce || out_free);
	assign in_ready = !valid_s1 || advance;

	// digit accumulate with saturation; acc*10 as two shifts
	always_comb begin
		field_acc = (phase_q == PH_SOCKET) ? sock_q : len_q;
		is_digit  = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
		acc_ext   = {1'b0, field_acc, 3'b000} + {3'b000, field_acc, 1'b0}
			+ {12'd0, byte_s1 - CHAR_ZERO};
		if (!is_digit)
			acc_next = field_acc;
		else if (acc_ext > {4'd0, ACC_MAX})
			acc_next = ACC_MAX;
		else
			acc_next = acc_ext[15:0];
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		hist_d   = hist_q;
		fcnt_d   = fcnt_q;
		sock_d   = sock_q;
		len_d    = len_q;
		lfcnt_d  = lfcnt_q;
		remain_d = remain_q;
		case (phase_q)
			PH_SOCKET, PH_LENGTH: begin
				if (byte_s1 == CHAR_COMMA) begin
					fcnt_d = '0;
					if (phase_q == PH_SOCKET) begin
						phase_d = PH_LENGTH;
					end else begin
						phase_d = PH_LINEFEEDS;
						lfcnt_d = '0;
					end
				end else if (fcnt_q >= CNT_MAX) begin
					phase_d  = PH_HUNT;
					hist_d   = '0;
					fcnt_d   = '0;
					sock_d   = '0;
					len_d    = '0;
					lfcnt_d  = '0;
					remain_d = '0;
				end else begin
					fcnt_d = fcnt_q + 1'b1;
					if (phase_q == PH_SOCKET)
						sock_d = acc_next;
					else
						len_d = acc_next;
				end
			end
			PH_LINEFEEDS: begin
				if (byte_s1 == CHAR_LF) begin
					lfcnt_d = lfcnt_q + 1'b1;
					if (lfcnt_d >= LF_MAX) begin
						if (len_q == '0) begin
							phase_d  = PH_HUNT;
							hist_d   = '0;
							fcnt_d   = '0;
							sock_d   = '0;
							len_d    = '0;
							lfcnt_d  = '0;
							remain_d = '0;
						end else begin
							phase_d  = PH_PAYLOAD;
							remain_d = len_q;
							lfcnt_d  = '0;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				if (remain_q <= 16'd1) begin
					phase_d  = PH_HUNT;
					hist_d   = '0;
					fcnt_d   = '0;
					sock_d   = '0;
					len_d    = '0;
					lfcnt_d  = '0;
					remain_d = '0;
				end else begin
					remain_d = remain_q - 16'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (hist_q == HEADER_WORD && byte_s1 == HEADER_LAST) begin
					phase_d  = PH_SOCKET;
					hist_d   = '0;
					fcnt_d   = '0;
					sock_d   = '0;
					len_d    = '0;
					lfcnt_d  = '0;
					remain_d = '0;
				end else begin
					hist_d = {hist_q[47:0], byte_s1};
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		produce = valid_s1 && (phase_q == PH_PAYLOAD);
		is_last = (remain_q <= 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			hist_q   <= '0;
			fcnt_q   <= '0;
			sock_q   <= '0;
			len_q    <= '0;
			lfcnt_q  <= '0;
			remain_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			hist_q   <= hist_d;
			fcnt_q   <= fcnt_d;
			sock_q   <= sock_d;
			len_q    <= len_d;
			lfcnt_q  <= lfcnt_d;
			remain_q <= remain_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_byte_q <= byte_s1;
			out_sock_q <= sock_q;
			out_last_q <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_byte_q;
	assign socket_id    = out_sock_q;
	assign frame_last   = out_last_q;

endmodule

// File: sv/srd_checker.sv
module srd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  payload_byte,
	input logic [15:0] socket_id,
	input logic        frame_last
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(socket_id) && $stable(frame_last))
		else $error("result word changed while stalled");

	// with the result register empty nothing can block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// the input only stalls behind a result word that is not being taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result word");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind socket_report_deframer srd_checker u_srd_checker (.*);
